/* hw/rtl/psrk_pkg.sv */
// ----------------------------------------------------------------------------
// psrk_pkg: shared types and constants for the population spike rate block
// Operation and status codes, field widths, and the Gaussian kernel ROM
// contents computed at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package psrk_pkg;

  // Sizing
  localparam int MaxSpikes     = 16384;
  localparam int BandwidthTicks = 100;
  localparam int KernelReach   = 512;

  localparam int TimeW   = 16;
  localparam int OpW     = 2;
  localparam int StatW   = 2;
  localparam int RateW   = 48;
  localparam int StCntW  = 15;
  localparam int ScaleW  = 32;
  localparam int KernW   = 24;

  localparam int IdxW    = $clog2(MaxSpikes);
  localparam int CntW    = $clog2(MaxSpikes + 1);
  localparam int KrIdxW  = $clog2(KernelReach);
  localparam int SumW    = CntW + KernW;
  localparam int HalfW   = ScaleW / 2;
  localparam int ProdW   = SumW + HalfW;
  localparam int RsW     = (ProdW - 7 > RateW + 1) ? ProdW - 7 : RateW + 1;

  localparam logic [RateW-1:0]  RateMax    = '1;
  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(65536);

  // Stream packing
  localparam int InDataW  = 2 * TimeW;
  localparam int OutDataW = ((RateW + StCntW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OpLoad  = 2'd0,
    OpEval  = 2'd1,
    OpClear = 2'd2
  } op_e;

  typedef enum logic [StatW-1:0] {
    StatOk   = 2'd0,
    StatDrop = 2'd1,
    StatSat  = 2'd2
  } status_e;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic             clear_sum;
    logic             smp_valid;
    logic             mul_en;
    logic [TimeW-1:0] eval_time;
  } psrk_ctrl_t;

  // Kernel ROM build (elaboration only)
  localparam logic [63:0] Q30One    = 64'd1073741824;
  localparam logic [63:0] InvSqrtQ24 = 64'd66931408;   // 10/sqrt(2*pi), Q24
  localparam logic [63:0] KernMax   = 64'd16777215;
  localparam logic [63:0] BwQ       = 64'(2 * BandwidthTicks * BandwidthTicks);
  localparam logic [63:0] RoundAdd  = 64'(BandwidthTicks) * (Q30One >> 1);
  localparam logic [63:0] RoundDiv  = 64'(BandwidthTicks) * Q30One;

  typedef logic [KernW-1:0] krom_t [KernelReach];

  // exp(-f), f in Q0.30, 24-term alternating series, Q30 result
  function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = Q30One;
    neg  = '0;
    term = Q30One;
    for (int unsigned k = 1; k <= 24; k++) begin
      term = ((term * f) >> 30) / 64'(k);
      if (k[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    return (pos > neg) ? pos - neg : '0;
  endfunction

  function automatic krom_t build_kernel_rom();
    krom_t       rom;
    logic [63:0] e1;
    logic [63:0] dd;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] r;
    logic [63:0] v;
    e1 = exp_neg_q30(Q30One);
    for (int unsigned d = 0; d < KernelReach; d++) begin
      dd = 64'(d) * 64'(d);
      n  = dd / BwQ;
      f  = ((dd % BwQ) << 30) / BwQ;
      if (n >= 64'd24) begin
        rom[d] = '0;
      end else begin
        r = exp_neg_q30(f);
        for (int unsigned i = 0; i < 24; i++) begin
          if (64'(i) < n) begin
            r = (r * e1) >> 30;
          end
        end
        v = (r * InvSqrtQ24 + RoundAdd) / RoundDiv;
        rom[d] = (v > KernMax) ? KernW'(KernMax) : v[KernW-1:0];
      end
    end
    return rom;
  endfunction

  localparam krom_t KernelRom = build_kernel_rom();

endpackage

`default_nettype wire

/* hw/rtl/psrk_spike_mem.sv */
// ----------------------------------------------------------------------------
// psrk_spike_mem: spike time store
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psrk_spike_mem
  import psrk_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IdxW-1:0]  waddr_i,
  input  wire logic [TimeW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [IdxW-1:0]  raddr_i,
  output logic      [TimeW-1:0] rdata_o
);

  logic [TimeW-1:0] mem_q [MaxSpikes];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/psrk_kde_dp.sv */
// ----------------------------------------------------------------------------
// psrk_kde_dp: kernel density datapath
// Distance, kernel ROM lookup, running sum, and rate scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module psrk_kde_dp
  import psrk_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire psrk_ctrl_t        ctrl_i,
  input  wire logic [TimeW-1:0]  sample_i,
  input  wire logic [ScaleW-1:0] rate_scale_i,
  output logic                   busy_o,
  output logic [RateW-1:0]       rate_o,
  output logic                   sat_o
);

  logic [TimeW-1:0]  delta;
  logic              near;
  logic [KrIdxW-1:0] d_q;
  logic              v2_q;
  logic [KernW-1:0]  k_q;
  logic              v3_q;
  logic [SumW-1:0]   sum_q;
  logic [ProdW-1:0]  a_q;
  logic [ProdW-1:0]  b_q;
  logic [ProdW:0]    lo_sum;
  logic [RsW-1:0]    r_full;

  // stage 2: distance to evaluation tick
  always_comb begin
    delta = (sample_i > ctrl_i.eval_time) ? sample_i - ctrl_i.eval_time
                                          : ctrl_i.eval_time - sample_i;
    near  = delta < TimeW'(KernelReach);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= ctrl_i.smp_valid & near;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= delta[KrIdxW-1:0];
    if (v2_q) begin
      k_q <= KernelRom[d_q];
    end
  end

  // accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.clear_sum) begin
      sum_q <= '0;
    end else if (v3_q) begin
      sum_q <= sum_q + SumW'(k_q);
    end
  end

  // scale split in two 16-bit halves
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      a_q <= ProdW'(sum_q) * ProdW'(rate_scale_i[ScaleW-1:HalfW]);
      b_q <= ProdW'(sum_q) * ProdW'(rate_scale_i[HalfW-1:0]);
    end
  end

  always_comb begin
    lo_sum = {{(ProdW + 1 - 24){1'b0}}, a_q[7:0], 16'b0} + {1'b0, b_q};
    r_full = RsW'(a_q[ProdW-1:8]) + RsW'(lo_sum[ProdW:24]);
    sat_o  = r_full > RsW'(RateMax);
    rate_o = sat_o ? RateMax : r_full[RateW-1:0];
  end

  assign busy_o = v2_q | v3_q;

endmodule

`default_nettype wire

/* hw/rtl/population_spike_rate_kde.sv */
// ----------------------------------------------------------------------------
// population_spike_rate_kde: population spike rate by Gaussian KDE
// Load and clear: result in the cycle after the input transfer.
// Evaluate: result once every held spike (up to 16384) has gone through the
//   one read port of the store into the sum, then the scale multiply.
// One item at a time; input ready in idle once the output register is free.
// Reset: async active low; count and rate_scale reset, store left undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module population_spike_rate_kde
  import psrk_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [15:0] spike_time, [31:16] eval_time
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] operation
  input  wire logic [OpW-1:0]      s_axis_tuser,
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [47:0] rate, [62:48] stored_count, [63] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  // [1:0] status
  output logic [StatW-1:0]         m_axis_tuser,
  // rate_scale register
  input  wire logic                cfg_we_i,
  input  wire logic [ScaleW-1:0]   cfg_wdata_i
);

  // Sequencer states
  localparam logic [1:0] StIdle = 2'd0;  // waiting for an item
  localparam logic [1:0] StRead = 2'd1;  // streaming the store through the datapath
  localparam logic [1:0] StMul  = 2'd2;  // scale multiply
  localparam logic [1:0] StFin  = 2'd3;  // final add, load output register

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              rd_pend_q;
  logic [TimeW-1:0]  et_q;
  logic [ScaleW-1:0] scale_q;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [StatW-1:0]  out_stat_q, out_stat_d;
  logic [RateW-1:0]  out_rate_q, out_rate_d;
  logic [StCntW-1:0] out_cnt_q, out_cnt_d;

  logic              in_xfer;
  logic [OpW-1:0]    op;
  logic [TimeW-1:0]  spike_time;
  logic [TimeW-1:0]  eval_time;
  logic              mem_we;
  logic              mem_re;
  logic [TimeW-1:0]  mem_rdata;
  psrk_ctrl_t        ctrl;
  logic              dp_busy;
  logic [RateW-1:0]  dp_rate;
  logic              dp_sat;

  assign op         = s_axis_tuser;
  assign spike_time = s_axis_tdata[TimeW-1:0];
  assign eval_time  = s_axis_tdata[2*TimeW-1:TimeW];

  // A new item is taken only in idle, and only when the output register
  // is empty or drains this cycle; every item then has a place to land.
  assign s_axis_tready = (state_q == StIdle) && (!out_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_stat_d  = out_stat_q;
    out_rate_d  = out_rate_q;
    out_cnt_d   = out_cnt_q;
    ctrl.clear_sum = 1'b0;
    ctrl.smp_valid = rd_pend_q;
    ctrl.mul_en    = 1'b0;
    ctrl.eval_time = et_q;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          case (op)
            OpLoad: begin
              // a full store drops the spike and flags it
              if (count_q >= CntW'(MaxSpikes)) begin
                out_stat_d = StatDrop;
              end else begin
                mem_we     = 1'b1;
                count_d    = count_q + 1'b1;
                out_stat_d = StatOk;
              end
              out_valid_d = 1'b1;
              out_rate_d  = '0;
              out_cnt_d   = StCntW'(count_d);
            end
            OpEval: begin
              ctrl.clear_sum = 1'b1;
              rd_idx_d       = '0;
              state_d        = StRead;
            end
            OpClear: begin
              count_d     = '0;
              out_valid_d = 1'b1;
              out_stat_d  = StatOk;
              out_rate_d  = '0;
              out_cnt_d   = '0;
            end
            default: begin
              out_valid_d = 1'b1;
              out_stat_d  = StatOk;
              out_rate_d  = '0;
              out_cnt_d   = StCntW'(count_q);
            end
          endcase
        end
      end
      StRead: begin
        // one store read per cycle; leave once the pipe has drained into the sum
        mem_re = rd_idx_q < count_q;
        if (mem_re) begin
          rd_idx_d = rd_idx_q + 1'b1;
        end else if (!rd_pend_q && !dp_busy) begin
          state_d = StMul;
        end
      end
      StMul: begin
        ctrl.mul_en = 1'b1;
        state_d     = StFin;
      end
      StFin: begin
        out_valid_d = 1'b1;
        out_stat_d  = dp_sat ? StatSat : StatOk;
        out_rate_d  = dp_rate;
        out_cnt_d   = StCntW'(count_q);
        state_d     = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      scale_q     <= ScaleReset;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      rd_pend_q   <= mem_re;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_stat_q <= out_stat_d;
    out_rate_q <= out_rate_d;
    out_cnt_q  <= out_cnt_d;
    if (in_xfer) begin
      et_q <= eval_time;
    end
  end

  psrk_spike_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (spike_time),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  psrk_kde_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .sample_i     (mem_rdata),
    .rate_scale_i (scale_q),
    .busy_o       (dp_busy),
    .rate_o       (dp_rate),
    .sat_o        (dp_sat)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_stat_q;
  assign m_axis_tdata  = {{(OutDataW - RateW - StCntW){1'b0}}, out_cnt_q, out_rate_q};

endmodule

`default_nettype wire

/* hw/rtl/psrk_checker.sv */
// ----------------------------------------------------------------------------
// psrk_checker: port-level checks for the population spike rate block
// Watches both streams and flags ordering and result-field slips.
// ----------------------------------------------------------------------------
`default_nettype none

module psrk_checker
  import psrk_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [OpW-1:0]      s_axis_tuser,
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [OutDataW-1:0] m_axis_tdata,
  input  wire logic [StatW-1:0]    m_axis_tuser
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // no new item while a result is stuck in the output register
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input ready while output stalled");

  // load gives its result in the next cycle
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tuser == OpLoad |=> m_axis_tvalid)
    else $error("load result missing");

  // clear reports an empty store
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && s_axis_tuser == OpClear |=>
      m_axis_tvalid && m_axis_tuser == StatOk &&
      m_axis_tdata[RateW+StCntW-1:RateW] == '0)
    else $error("clear result wrong");

  // a dropped spike carries no rate
  a_drop_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == StatDrop |-> m_axis_tdata[RateW-1:0] == '0)
    else $error("rate on dropped load");

endmodule

bind population_spike_rate_kde psrk_checker u_psrk_checker (.*);

`default_nettype wire
